// ===== hdl/hcsg_pkg.sv =====
package hcsg_pkg;

    // Sizes of the curve and of the drawing area.
    localparam int MaxOrder   = 9;
    localparam int CanvasSize = 1024;
    localparam int CanvasW    = $clog2(CanvasSize) + 1;
    localparam int CoordW     = 10;
    localparam int OrderW     = 4;
    localparam int DepthW     = 4;
    localparam int PosW       = 4;
    localparam int HeadW      = 2;
    localparam int UpcW       = 4;

    // Rule text positions.
    localparam int RuleLen = 11;
    localparam int LastPos = 9;
    localparam int DonePos = 10;

    localparam logic [OrderW-1:0] ResetOrder = 4'd6;

    // One stack frame: which rule and the next character position in it.
    typedef struct packed {
        logic            rule;
        logic [PosW-1:0] pos;
    } frame_t;

    // Symbols of the rewriting rules.
    typedef enum logic [2:0] {
        SYM_PLUS,
        SYM_MINUS,
        SYM_X,
        SYM_Y,
        SYM_F
    } sym_t;

    // Datapath operations selected by the microcode.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_START,
        OP_WALK,
        OP_MOVE,
        OP_NONE
    } op_t;

    // Jump conditions of the sequencer.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_NOT_RESTART,
        C_FINISHED,
        C_WALK_AGAIN,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [UpcW-1:0] target;
    } uword_t;

    // Status flags from the datapath to the sequencer.
    typedef struct packed {
        logic finished;
        logic walk_again;
        logic out_busy;
    } dp_status_t;

    // Microprogram addresses.
    localparam logic [UpcW-1:0] UA_WAIT      = 4'd0;
    localparam logic [UpcW-1:0] UA_DISPATCH  = 4'd1;
    localparam logic [UpcW-1:0] UA_START     = 4'd2;
    localparam logic [UpcW-1:0] UA_CHECK     = 4'd3;
    localparam logic [UpcW-1:0] UA_WALK      = 4'd4;
    localparam logic [UpcW-1:0] UA_FOUND     = 4'd5;
    localparam logic [UpcW-1:0] UA_MOVE_WAIT = 4'd6;
    localparam logic [UpcW-1:0] UA_MOVE      = 4'd7;
    localparam logic [UpcW-1:0] UA_NONE_WAIT = 4'd8;
    localparam logic [UpcW-1:0] UA_NONE      = 4'd9;

    // Symbol at a position of rule X (rule = 0) or rule Y (rule = 1).
    function automatic sym_t rule_sym(input logic rule, input logic [PosW-1:0] pos);
        sym_t s;
        s = SYM_F;
        case (pos)
            4'd0, 4'd10: s = rule ? SYM_MINUS : SYM_PLUS;
            4'd1, 4'd9:  s = rule ? SYM_X : SYM_Y;
            4'd3, 4'd7:  s = rule ? SYM_PLUS : SYM_MINUS;
            4'd4, 4'd6:  s = rule ? SYM_Y : SYM_X;
            default:     s = SYM_F;
        endcase
        return s;
    endfunction

    // Control store: one word per microprogram address.
    function automatic uword_t ucode(input logic [UpcW-1:0] addr);
        uword_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: UA_WAIT};
        unique case (addr)
            UA_WAIT:      w = '{op: OP_NOP,   cond: C_NO_ITEM,     target: UA_WAIT};
            UA_DISPATCH:  w = '{op: OP_NOP,   cond: C_NOT_RESTART, target: UA_CHECK};
            UA_START:     w = '{op: OP_START, cond: C_NEVER,       target: UA_WAIT};
            UA_CHECK:     w = '{op: OP_NOP,   cond: C_FINISHED,    target: UA_NONE_WAIT};
            UA_WALK:      w = '{op: OP_WALK,  cond: C_WALK_AGAIN,  target: UA_WALK};
            UA_FOUND:     w = '{op: OP_NOP,   cond: C_FINISHED,    target: UA_NONE_WAIT};
            UA_MOVE_WAIT: w = '{op: OP_NOP,   cond: C_OUT_BUSY,    target: UA_MOVE_WAIT};
            UA_MOVE:      w = '{op: OP_MOVE,  cond: C_ALWAYS,      target: UA_WAIT};
            UA_NONE_WAIT: w = '{op: OP_NOP,   cond: C_OUT_BUSY,    target: UA_NONE_WAIT};
            UA_NONE:      w = '{op: OP_NONE,  cond: C_ALWAYS,      target: UA_WAIT};
            default:      w = '{op: OP_NOP,   cond: C_ALWAYS,      target: UA_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/hcsg_sequencer.sv =====
module hcsg_sequencer
    import hcsg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       restart,
    input  dp_status_t status,
    output op_t        op
);

    logic [UpcW-1:0] upc_reg;
    logic [UpcW-1:0] upc_next;
    logic            restart_reg;
    logic            restart_next;
    logic            take;
    logic            jump;
    uword_t          word;

    // Items are taken only while the program waits at its entry point.
    assign in_stall = (upc_reg != UA_WAIT);
    assign take     = in_valid && !in_stall;

    assign word = ucode(upc_reg);
    assign op   = word.op;

    // Jump condition select.
    always_comb
    begin
        jump = 1'b0;
        unique case (word.cond)
            C_NEVER:       jump = 1'b0;
            C_ALWAYS:      jump = 1'b1;
            C_NO_ITEM:     jump = !in_valid;
            C_NOT_RESTART: jump = !restart_reg;
            C_FINISHED:    jump = status.finished;
            C_WALK_AGAIN:  jump = status.walk_again;
            C_OUT_BUSY:    jump = status.out_busy;
            default:       jump = 1'b1;
        endcase
    end

    always_comb
    begin
        upc_next     = jump ? word.target : upc_reg + UpcW'(1);
        restart_next = take ? restart : restart_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg     <= UA_WAIT;
            restart_reg <= 1'b0;
        end
        else
        begin
            upc_reg     <= upc_next;
            restart_reg <= restart_next;
        end
    end

    // An accepted item is decoded in the following cycle.
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (upc_reg == UA_DISPATCH))
        else $error("accepted item not dispatched");

    // A restart item goes on to the start step.
    a_restart_start: assert property (@(posedge clk) disable iff (!rst_n)
        (take && restart) |=> ##1 (upc_reg == UA_START))
        else $error("restart item skipped the start step");

    // The program counter stays inside the microprogram.
    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= UA_NONE)
        else $error("program counter left the microprogram");

endmodule

// ===== hdl/hcsg_datapath.sv =====
module hcsg_datapath
    import hcsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [OrderW-1:0] curve_order,
    input  op_t               op,
    output dp_status_t        status,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CoordW-1:0] from_x,
    output logic [CoordW-1:0] from_y,
    output logic [CoordW-1:0] to_x,
    output logic [CoordW-1:0] to_y,
    output logic [HeadW-1:0]  heading,
    output logic              last_segment,
    output logic              valid_res
);

    // Configuration and traversal state.
    logic [OrderW-1:0] curve_order_reg;
    logic [OrderW-1:0] curve_order_next;
    logic [OrderW-1:0] active_order_reg;
    logic [OrderW-1:0] active_order_next;
    logic [DepthW-1:0] depth_reg;
    logic [DepthW-1:0] depth_next;
    logic [HeadW-1:0]  dir_reg;
    logic [HeadW-1:0]  dir_next;
    logic [CoordW-1:0] pen_x_reg;
    logic [CoordW-1:0] pen_x_next;
    logic [CoordW-1:0] pen_y_reg;
    logic [CoordW-1:0] pen_y_next;
    logic              finished_reg;
    logic              finished_next;
    frame_t            stack_reg [MaxOrder];

    // Output register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CoordW-1:0] from_x_reg;
    logic [CoordW-1:0] from_y_reg;
    logic [CoordW-1:0] to_x_reg;
    logic [CoordW-1:0] to_y_reg;
    logic [HeadW-1:0]  heading_reg;
    logic              last_reg;
    logic              valid_res_reg;

    logic [OrderW-1:0]  order_sat;
    logic [CanvasW-1:0] unit_full;
    logic [CanvasW-1:0] half_unit;
    logic [CanvasW-1:0] start_y;
    logic [CoordW-1:0]  unit;
    logic [DepthW-1:0]  top_idx;
    frame_t             top;
    sym_t               sym;
    logic               pos_end;
    logic               is_last;
    logic               out_busy;
    logic               load_out;
    logic               top_we;
    frame_t             top_wdata;
    logic               push_we;
    frame_t             push_wdata;

    // Start point and segment length from the order.
    assign order_sat = (curve_order_reg > OrderW'(MaxOrder)) ? OrderW'(MaxOrder)
                                                             : curve_order_reg;
    assign unit_full = CanvasW'(CanvasSize) >> order_sat;
    assign half_unit = unit_full >> 1;
    assign start_y   = CanvasW'(CanvasSize) - half_unit;
    assign unit      = CoordW'(CanvasW'(CanvasSize) >> active_order_reg);

    // Top frame of the stack and the symbol it points at.
    assign top_idx = depth_reg - DepthW'(1);
    always_comb
    begin
        top = '0;
        if (depth_reg != '0)
        begin
            top = stack_reg[top_idx];
        end
    end
    assign sym     = rule_sym(top.rule, top.pos);
    assign pos_end = (top.pos >= PosW'(RuleLen));

    // The walk carries on until it consumes a draw symbol or empties the stack.
    assign status.walk_again = (depth_reg != '0) && !(!pos_end && (sym == SYM_F));
    assign status.finished   = finished_reg;

    // Last segment: deepest frame just past its final draw, all others spent.
    always_comb
    begin
        is_last = (depth_reg == active_order_reg) && (depth_reg != '0)
                  && (top.pos == PosW'(LastPos));
        for (int k = 0; k < MaxOrder; k++)
        begin
            if ((DepthW'(k) + DepthW'(1) < depth_reg)
                && (stack_reg[k].pos != PosW'(DonePos)))
            begin
                is_last = 1'b0;
            end
        end
    end

    assign out_busy        = out_valid_reg && out_stall;
    assign status.out_busy = out_busy;
    assign load_out        = (op == OP_MOVE) || (op == OP_NONE);

    // Next state of the traversal.
    always_comb
    begin
        curve_order_next  = cfg_we ? curve_order : curve_order_reg;
        active_order_next = active_order_reg;
        depth_next        = depth_reg;
        dir_next          = dir_reg;
        pen_x_next        = pen_x_reg;
        pen_y_next        = pen_y_reg;
        finished_next     = finished_reg;
        top_we            = 1'b0;
        top_wdata         = '{rule: top.rule, pos: top.pos + PosW'(1)};
        push_we           = 1'b0;
        push_wdata        = '{rule: (sym == SYM_Y), pos: '0};

        unique case (op)
            OP_START:
            begin
                active_order_next = order_sat;
                dir_next          = '0;
                pen_x_next        = half_unit[CoordW-1:0];
                pen_y_next        = start_y[CoordW-1:0];
                finished_next     = (order_sat == '0);
                depth_next        = (order_sat == '0) ? DepthW'(0) : DepthW'(1);
            end
            OP_WALK:
            begin
                if (depth_reg == '0)
                begin
                    finished_next = 1'b1;
                end
                else if (pos_end)
                begin
                    depth_next = depth_reg - DepthW'(1);
                end
                else
                begin
                    top_we = 1'b1;
                    case (sym)
                        SYM_PLUS:  dir_next = dir_reg + HeadW'(1);
                        SYM_MINUS: dir_next = dir_reg - HeadW'(1);
                        SYM_X, SYM_Y:
                        begin
                            if (depth_reg < active_order_reg)
                            begin
                                push_we    = 1'b1;
                                depth_next = depth_reg + DepthW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_MOVE:
            begin
                case (dir_reg)
                    2'd0:    pen_x_next = pen_x_reg + unit;
                    2'd1:    pen_y_next = pen_y_reg - unit;
                    2'd2:    pen_x_next = pen_x_reg - unit;
                    default: pen_y_next = pen_y_reg + unit;
                endcase
                if (is_last)
                begin
                    finished_next = 1'b1;
                end
            end
            OP_NOP, OP_NONE: ;
            default: ;
        endcase
    end

    // Output register empties when taken and refills from a move or an empty result.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_order_reg  <= ResetOrder;
            active_order_reg <= '0;
            depth_reg        <= '0;
            dir_reg          <= '0;
            pen_x_reg        <= '0;
            pen_y_reg        <= '0;
            finished_reg     <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            curve_order_reg  <= curve_order_next;
            active_order_reg <= active_order_next;
            depth_reg        <= depth_next;
            dir_reg          <= dir_next;
            pen_x_reg        <= pen_x_next;
            pen_y_reg        <= pen_y_next;
            finished_reg     <= finished_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Frame stack: the start step seeds the bottom frame with rule X.
    always_ff @(posedge clk)
    begin
        if (op == OP_START)
        begin
            stack_reg[0] <= '0;
        end
        if (top_we)
        begin
            stack_reg[top_idx] <= top_wdata;
        end
        if (push_we)
        begin
            stack_reg[depth_reg] <= push_wdata;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (op == OP_MOVE)
        begin
            from_x_reg    <= pen_x_reg;
            from_y_reg    <= pen_y_reg;
            to_x_reg      <= pen_x_next;
            to_y_reg      <= pen_y_next;
            heading_reg   <= dir_reg;
            last_reg      <= is_last;
            valid_res_reg <= 1'b1;
        end
        else if (op == OP_NONE)
        begin
            from_x_reg    <= '0;
            from_y_reg    <= '0;
            to_x_reg      <= '0;
            to_y_reg      <= '0;
            heading_reg   <= '0;
            last_reg      <= 1'b0;
            valid_res_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign from_x       = from_x_reg;
    assign from_y       = from_y_reg;
    assign to_x         = to_x_reg;
    assign to_y         = to_y_reg;
    assign heading      = heading_reg;
    assign last_segment = last_reg;
    assign valid_res    = valid_res_reg;

    // The stack never grows past the order of the running curve.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= active_order_reg)
        else $error("stack deeper than the curve order");

    // A result is only written into a free output register.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_busy)
        else $error("output register overwritten while stalled");

    // The last segment ends the curve.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_MOVE && is_last) |=> finished_reg)
        else $error("curve not finished after its last segment");

endmodule

// ===== hdl/hilbert_curve_step_generator.sv =====
// Hilbert curve segment generator, driven by a small microprogram.
// An item passes dispatch, a start step (restart items only), a check, the walk steps (one
// per symbol or pop) and a found step, then waits while the output register is stalled and
// loads the segment; a curve finished at the check or the found step gives an empty result.
// Throughput: one item at a time; the next item is taken once the result is loaded.
// Reset clears the traversal (curve finished), sets the order to 6, empties the output.
module hilbert_curve_step_generator
    import hcsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [OrderW-1:0] curve_order,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              restart,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CoordW-1:0] from_x,
    output logic [CoordW-1:0] from_y,
    output logic [CoordW-1:0] to_x,
    output logic [CoordW-1:0] to_y,
    output logic [HeadW-1:0]  heading,
    output logic              last_segment,
    output logic              valid_res
);

    op_t        op;
    dp_status_t status;

    // Program counter, control store and jump logic.
    hcsg_sequencer u_sequencer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .restart  (restart),
        .status   (status),
        .op       (op)
    );

    // Frame stack, pen, heading and output register.
    hcsg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .curve_order  (curve_order),
        .op           (op),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .from_x       (from_x),
        .from_y       (from_y),
        .to_x         (to_x),
        .to_y         (to_y),
        .heading      (heading),
        .last_segment (last_segment),
        .valid_res    (valid_res)
    );

endmodule

// ===== bench/hilbert_curve_step_generator_test.sv =====
module hilbert_curve_step_generator_test;
    import hcsg_pkg::*;

    localparam int ItemTarget = 1750;
    localparam int IdleLimit  = 2000;
    localparam int HoldCycles = 150;
    localparam int DrainWait  = 40;
    localparam int PlanLen    = 23;

    // One segment as the block reports it.
    typedef struct packed {
        logic [CoordW-1:0] from_x;
        logic [CoordW-1:0] from_y;
        logic [CoordW-1:0] to_x;
        logic [CoordW-1:0] to_y;
        logic [HeadW-1:0]  heading;
        logic              last_segment;
        logic              valid_res;
    } seg_t;

    // One row of the directed part: optional order write, then one item.
    typedef struct packed {
        logic              wr;
        logic [OrderW-1:0] ord;
        logic              rs;
        logic              typed;
        seg_t              exp;
    } row_t;

    // Symbols of the two rewriting rules, X first, then Y.
    localparam sym_t RuleSyms [2][RuleLen] = '{
        '{SYM_PLUS, SYM_Y, SYM_F, SYM_MINUS, SYM_X, SYM_F, SYM_X, SYM_MINUS, SYM_F, SYM_Y,
          SYM_PLUS},
        '{SYM_MINUS, SYM_X, SYM_F, SYM_PLUS, SYM_Y, SYM_F, SYM_Y, SYM_PLUS, SYM_F, SYM_X,
          SYM_MINUS}
    };

    // Directed items. Typed expectations cover reset, order one and order zero.
    localparam row_t Plan [PlanLen] = '{
        '{1'b0, 4'd0,  1'b0, 1'b1, '0},
        '{1'b0, 4'd0,  1'b1, 1'b0, '0},
        '{1'b0, 4'd0,  1'b0, 1'b0, '0},
        '{1'b1, 4'd1,  1'b1, 1'b1, '{10'd256, 10'd768, 10'd256, 10'd256, 2'd1, 1'b0, 1'b1}},
        '{1'b0, 4'd0,  1'b0, 1'b1, '{10'd256, 10'd256, 10'd768, 10'd256, 2'd0, 1'b0, 1'b1}},
        '{1'b0, 4'd0,  1'b0, 1'b1, '{10'd768, 10'd256, 10'd768, 10'd768, 2'd3, 1'b1, 1'b1}},
        '{1'b0, 4'd0,  1'b0, 1'b1, '0},
        '{1'b1, 4'd0,  1'b1, 1'b1, '0},
        '{1'b0, 4'd0,  1'b0, 1'b1, '0},
        '{1'b1, 4'd15, 1'b1, 1'b0, '0},
        '{1'b0, 4'd0,  1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  1'b0, 1'b0, '0},
        '{1'b1, 4'd9,  1'b1, 1'b0, '0},
        '{1'b0, 4'd0,  1'b0, 1'b0, '0},
        '{1'b1, 4'd2,  1'b1, 1'b0, '0},
        '{1'b0, 4'd0,  1'b0, 1'b0, '0},
        '{1'b1, 4'd3,  1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  1'b1, 1'b0, '0},
        '{1'b0, 4'd0,  1'b0, 1'b0, '0},
        '{1'b1, 4'd10, 1'b1, 1'b0, '0},
        '{1'b0, 4'd0,  1'b0, 1'b0, '0},
        '{1'b0, 4'd0,  1'b1, 1'b0, '0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [OrderW-1:0] curve_order = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              restart = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CoordW-1:0] from_x;
    logic [CoordW-1:0] from_y;
    logic [CoordW-1:0] to_x;
    logic [CoordW-1:0] to_y;
    logic [HeadW-1:0]  heading;
    logic              last_segment;
    logic              valid_res;

    // Side data travelling with each item: a typed expectation, if any.
    logic item_typed = 1'b0;
    seg_t item_exp = '0;

    // Shared test control.
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int mismatches = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    seg_t segs_due [$];

    // Predictor state, matching the block after reset.
    frame_t            walk_stack [MaxOrder];
    int                walk_depth = 0;
    int                drawn_order = 0;
    logic [HeadW-1:0]  pen_heading = '0;
    logic [CoordW-1:0] pen_x = '0;
    logic [CoordW-1:0] pen_y = '0;
    bit                curve_done = 1'b1;
    logic [OrderW-1:0] order_reg = ResetOrder;

    hilbert_curve_step_generator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .curve_order  (curve_order),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .from_x       (from_x),
        .from_y       (from_y),
        .to_x         (to_x),
        .to_y         (to_y),
        .heading      (heading),
        .last_segment (last_segment),
        .valid_res    (valid_res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Random idle length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Advances the curve walk by one item and returns the segment it draws.
    function automatic seg_t hilbert_next(input logic rs);
        seg_t              seg;
        int unsigned       seg_len;
        frame_t            fr;
        sym_t              s;
        bit                found;
        bit                last;
        logic [CoordW-1:0] fx;
        logic [CoordW-1:0] fy;
        seg = '0;
        // A restart latches the order and puts the pen at the start point.
        if (rs)
        begin
            drawn_order = (order_reg > MaxOrder) ? MaxOrder : int'(order_reg);
            seg_len = CanvasSize >> drawn_order;
            pen_heading = '0;
            pen_x = CoordW'(seg_len / 2);
            pen_y = CoordW'(CanvasSize - seg_len / 2);
            if (drawn_order == 0)
            begin
                walk_depth = 0;
                curve_done = 1'b1;
            end
            else
            begin
                walk_stack[0] = '{rule: 1'b0, pos: '0};
                walk_depth = 1;
                curve_done = 1'b0;
            end
        end
        if (curve_done)
            return seg;
        seg_len = CanvasSize >> drawn_order;
        // Step through the rules until the next draw symbol.
        found = 1'b0;
        while (!found)
        begin
            if (walk_depth == 0)
            begin
                curve_done = 1'b1;
                return seg;
            end
            fr = walk_stack[walk_depth-1];
            if (fr.pos >= RuleLen)
            begin
                walk_depth--;
            end
            else
            begin
                s = RuleSyms[fr.rule][fr.pos];
                walk_stack[walk_depth-1].pos = fr.pos + 1'b1;
                case (s)
                    SYM_PLUS:  pen_heading = pen_heading + 1'b1;
                    SYM_MINUS: pen_heading = pen_heading - 1'b1;
                    SYM_X, SYM_Y:
                    begin
                        if (walk_depth < drawn_order)
                        begin
                            walk_stack[walk_depth] = '{rule: (s == SYM_Y), pos: '0};
                            walk_depth++;
                        end
                    end
                    default: found = 1'b1;
                endcase
            end
        end
        // Draw one unit in the current heading; the pen wraps at the canvas edge.
        fx = pen_x;
        fy = pen_y;
        case (pen_heading)
            2'd0:    pen_x = pen_x + CoordW'(seg_len);
            2'd1:    pen_y = pen_y - CoordW'(seg_len);
            2'd2:    pen_x = pen_x - CoordW'(seg_len);
            default: pen_y = pen_y + CoordW'(seg_len);
        endcase
        // The last segment comes from the final draw of every open frame.
        last = (walk_depth == drawn_order) && (walk_depth != 0)
            && (walk_stack[walk_depth-1].pos == LastPos);
        for (int k = 0; k + 1 < walk_depth; k++)
            if (walk_stack[k].pos != DonePos)
                last = 1'b0;
        if (last)
            curve_done = 1'b1;
        seg = '{fx, fy, pen_x, pen_y, pen_heading, last, 1'b1};
        return seg;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Monitor: check each result item, then predict for each accepted item.
    always @(posedge clk)
    begin : monitor
        seg_t got;
        seg_t want;
        seg_t pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{from_x, from_y, to_x, to_y, heading, last_segment, valid_res};
                if (segs_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result item with nothing expected, got %h", $time, got);
                end
                else
                begin
                    want = segs_due.pop_front();
                    check_field("from_x", want.from_x, got.from_x);
                    check_field("from_y", want.from_y, got.from_y);
                    check_field("to_x", want.to_x, got.to_x);
                    check_field("to_y", want.to_y, got.to_y);
                    check_field("heading", want.heading, got.heading);
                    check_field("last_segment", want.last_segment, got.last_segment);
                    check_field("valid_res", want.valid_res, got.valid_res);
                end
            end
            if (cfg_we)
                order_reg = curve_order;
            if (in_valid && !in_stall)
            begin
                pred = hilbert_next(restart);
                segs_due.push_back(item_typed ? item_exp : pred);
            end
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles == IdleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: random stalls, and a long hold-off whenever one is requested.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HoldCycles;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = calm ? 0 : gap_len();
            end
        end
    end

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_item(input logic rs, input logic typed, input seg_t exp);
        int gap;
        gap = calm ? 0 : gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            restart <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart <= rs;
        item_typed <= typed;
        item_exp <= exp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Writes the order register once every expected result has arrived.
    // The first edge lets the monitor record an item accepted just before.
    task automatic write_order(input logic [OrderW-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (segs_due.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        curve_order <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus: directed rows, then random curve phases, then the drain.
    initial
    begin : stimulus
        int               pick;
        int               run;
        int               eff;
        int               phase_no;
        logic [OrderW-1:0] ord;
        logic [OrderW-1:0] ord_now;
        ord_now = ResetOrder;
        phase_no = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PlanLen; i++)
        begin
            if (Plan[i].wr)
            begin
                write_order(Plan[i].ord);
                ord_now = Plan[i].ord;
            end
            send_item(Plan[i].rs, Plan[i].typed, Plan[i].exp);
        end

        // Mostly whole curves of small order, with restarts, overruns and
        // order changes mid-curve mixed in.
        while (items_sent < ItemTarget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                ord = OrderW'($urandom_range(1, 3));
            else if (pick < 70)
                ord = OrderW'($urandom_range(4, 5));
            else if (pick < 85)
                ord = OrderW'($urandom_range(6, 9));
            else if (pick < 92)
                ord = '0;
            else
                ord = OrderW'($urandom_range(10, 15));
            if ($urandom_range(0, 4) != 0)
            begin
                write_order(ord);
                ord_now = ord;
            end
            calm = ($urandom_range(0, 5) == 0);
            if (phase_no == 0 || $urandom_range(0, 19) == 0)
                hold_req = 1'b1;
            eff = (ord_now > MaxOrder) ? MaxOrder : int'(ord_now);
            if (eff <= 4)
                run = (4 ** eff) - 1 + $urandom_range(1, 3);
            else
                run = $urandom_range(20, 80);
            for (int k = 0; k < run; k++)
            begin
                if (k == 0)
                    send_item(1'($urandom_range(0, 7) != 0), 1'b0, '0);
                else
                    send_item(1'($urandom_range(0, 49) == 0), 1'b0, '0);
            end
            calm = 1'b0;
            phase_no++;
        end

        // Let the monitor record the final item before waiting for its result.
        in_valid <= 1'b0;
        @(posedge clk);
        while (segs_due.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/hcsg_pkg.sv
hdl/hcsg_sequencer.sv
hdl/hcsg_datapath.sv
hdl/hilbert_curve_step_generator.sv
bench/hilbert_curve_step_generator_test.sv
